/* src/ove_pkg.sv */
// shared types and constants for the ordered varint encoder
package ove_pkg;

  localparam int unsigned STREAM_W = 80;

  localparam logic [63:0] ONE_BYTE_MAX   = 64'd240;
  localparam logic [63:0] TWO_BYTE_MAX   = 64'd2287;
  localparam logic [63:0] THREE_BYTE_MAX = 64'd67823;
  localparam logic [11:0] TWO_BYTE_BIAS  = 12'd240;
  localparam logic [16:0] THREE_BYTE_BIAS = 17'd2288;
  localparam logic [7:0]  HDR_TWO_BASE   = 8'd241;
  localparam logic [7:0]  HDR_THREE      = 8'hF9;
  localparam logic [7:0]  HDR_LONG_BASE  = 8'hFA;

  typedef struct packed {
    logic [63:0] value;
    logic [7:0]  kind_byte;
    logic        invert;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // byte stream of one item, first byte in the top bits, plus its byte count
  typedef struct packed {
    logic [STREAM_W-1:0] stream;
    logic [3:0]          count;
  } desc_t;

endpackage

/* src/ordered_varint_encoder.sv */
// top level of the order-preserving varint encoder
//
//   channel | handshake         | payload
//   --------+-------------------+---------------------------------------
//   item    | push / full       | value, kind_byte, invert
//   result  | empty / pop       | out_byte, last (one byte per result)
//
// an item gives one to ten bytes and the back end sends one byte a cycle,
// while the result register is free or being popped, one result per byte
// the first byte passes the queue, shift and result registers to result
// the descriptor queue lets new items in while earlier bytes still wait
// reset is synchronous and clears the queue and the byte sequencer
module ordered_varint_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  ove_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output ove_pkg::out_item_t result
);

  ove_pkg::desc_t front_desc;
  ove_pkg::desc_t head_desc;
  logic           q_write;
  logic           q_take;
  logic           q_nonempty;

  assign q_write = push && !full;

  ove_front u_front (
    .item (item),
    .desc (front_desc)
  );

  ove_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_write),
    .wr_data  (front_desc),
    .rd_en    (q_take),
    .rd_data  (head_desc),
    .full     (full),
    .nonempty (q_nonempty)
  );

  ove_back u_back (
    .clk        (clk),
    .rst        (rst),
    .desc_avail (q_nonempty),
    .desc       (head_desc),
    .desc_take  (q_take),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

/* src/ove_front.sv */
// front end: classifies an item and builds its byte stream
module ove_front (
  input  ove_pkg::in_item_t item,
  output ove_pkg::desc_t    desc
);

  logic [63:0] v;
  logic [7:0]  mask;
  logic [11:0] diff2;
  logic [16:0] diff3;
  logic [2:0]  len_extra;
  logic [7:0]  header;
  logic [63:0] payload;
  logic [3:0]  n_data;
  logic [71:0] enc;
  logic        has_tag;

  assign v       = item.value;
  assign mask    = {8{item.invert}};
  assign diff2   = v[11:0] - ove_pkg::TWO_BYTE_BIAS;
  assign diff3   = v[16:0] - ove_pkg::THREE_BYTE_BIAS;
  assign has_tag = (item.kind_byte != 8'd0);

  // extra length beyond three bytes for the long form
  always_comb begin
    if (v[63:56] != 8'd0) begin
      len_extra = 3'd5;
    end else if (v[55:48] != 8'd0) begin
      len_extra = 3'd4;
    end else if (v[47:40] != 8'd0) begin
      len_extra = 3'd3;
    end else if (v[39:32] != 8'd0) begin
      len_extra = 3'd2;
    end else if (v[31:24] != 8'd0) begin
      len_extra = 3'd1;
    end else begin
      len_extra = 3'd0;
    end
  end

  always_comb begin
    if (v <= ove_pkg::ONE_BYTE_MAX) begin
      header  = v[7:0];
      payload = 64'd0;
      n_data  = 4'd0;
    end else if (v <= ove_pkg::TWO_BYTE_MAX) begin
      header  = ove_pkg::HDR_TWO_BASE + {4'd0, diff2[11:8]};
      payload = {diff2[7:0], 56'd0};
      n_data  = 4'd1;
    end else if (v <= ove_pkg::THREE_BYTE_MAX) begin
      header  = ove_pkg::HDR_THREE;
      payload = {diff3[15:0], 48'd0};
      n_data  = 4'd2;
    end else begin
      header = ove_pkg::HDR_LONG_BASE + {5'd0, len_extra};
      n_data = 4'd3 + {1'b0, len_extra};
      case (len_extra)
        3'd0:    payload = {v[23:0], 40'd0};
        3'd1:    payload = {v[31:0], 32'd0};
        3'd2:    payload = {v[39:0], 24'd0};
        3'd3:    payload = {v[47:0], 16'd0};
        3'd4:    payload = {v[55:0], 8'd0};
        default: payload = v;
      endcase
    end
  end

  assign enc = {header, payload} ^ {9{mask}};

  always_comb begin
    if (has_tag) begin
      desc.stream = {item.kind_byte, enc};
      desc.count  = n_data + 4'd2;
    end else begin
      desc.stream = {enc, 8'd0};
      desc.count  = n_data + 4'd1;
    end
  end

endmodule

/* src/ove_queue.sv */
// short register queue of byte-stream descriptors between front and back
module ove_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  ove_pkg::desc_t wr_data,
  input  logic           rd_en,
  output ove_pkg::desc_t rd_data,
  output logic           full,
  output logic           nonempty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  ove_pkg::desc_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [CNT_W-1:0] count_next;

  assign full     = (count == CNT_FULL);
  assign nonempty = (count != '0);
  assign rd_data  = entries[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (wr_en) begin
      wr_ptr_next = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_next = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      count_next = count + CNT_W'(1);
    end else if (!wr_en && rd_en) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

/* src/ove_back.sv */
// back end: shifts out one byte per cycle into the result register while it is free or popped
module ove_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                desc_avail,
  input  ove_pkg::desc_t      desc,
  output logic                desc_take,
  output ove_pkg::out_item_t  result,
  output logic                empty,
  input  logic                pop
);

  logic [ove_pkg::STREAM_W-1:0] sr;
  logic [ove_pkg::STREAM_W-1:0] sr_next;
  logic [3:0]                   rem;
  logic [3:0]                   rem_next;
  logic                         out_valid;
  logic                         out_valid_next;
  ove_pkg::out_item_t           out_q;
  logic                         active;
  logic                         emit;

  assign active    = (rem != 4'd0);
  assign emit      = active && (!out_valid || pop);
  // load the next item when idle or on the cycle the current one sends its final byte
  assign desc_take = desc_avail && (!active || (emit && rem == 4'd1));

  always_comb begin
    sr_next  = sr;
    rem_next = rem;
    if (desc_take) begin
      sr_next  = desc.stream;
      rem_next = desc.count;
    end else if (emit) begin
      sr_next  = {sr[ove_pkg::STREAM_W-9:0], 8'd0};
      rem_next = rem - 4'd1;
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_next = 1'b1;
    end else if (pop) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      rem       <= rem_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    sr <= sr_next;
    if (emit) begin
      out_q.out_byte <= sr[ove_pkg::STREAM_W-1 -: 8];
      out_q.last     <= (rem == 4'd1);
    end
  end

  assign result = out_q;
  assign empty  = !out_valid;

endmodule

/* src/ove_checker.sv */
// port-level checks for the ordered varint encoder, bound to the top level
module ove_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input ove_pkg::out_item_t result
);

  logic [7:0] inflight;
  logic [3:0] run;

  // items accepted whose final byte has not yet been taken
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 8'd0;
      run      <= 4'd0;
    end else begin
      inflight <= inflight + 8'((push && !full) ? 1 : 0)
                  - 8'((pop && !empty && result.last) ? 1 : 0);
      if (pop && !empty) begin
        run <= result.last ? 4'd0 : run + 4'd1;
      end
    end
  end

  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result shown straight after reset");

  a_no_invented_bytes: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (inflight != 8'd0))
    else $error("result shown with no item outstanding");

  a_max_ten_bytes: assert property (@(posedge clk) disable iff (rst)
    (!empty && run == 4'd9) |-> result.last)
    else $error("item encoding longer than ten bytes");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed before it was taken");

endmodule

bind ordered_varint_encoder ove_checker u_ove_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
